FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(label, prop, msg)

`define ASSERT_NEVER(label, expr, msg)

`endif

`endif

FILE: rtl/dttgd_pkg.sv
// ----------------------------------------------------------------------------
// Dual touch tap gesture detector package
// Item types, event codes and register indexes shared by all modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dttgd_pkg;

    localparam int TIME_W      = 32;
    localparam int CFG_W       = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int SRC_W       = 2;
    localparam int CODE_W      = 3;
    localparam int PAD_SLOTS   = 2;
    localparam int NUM_SLOTS   = 6;

    localparam int SLOT_PAD_A   = 0;
    localparam int SLOT_PAD_B   = 2;
    localparam int SLOT_SIMUL   = 4;
    localparam int SLOT_SWIPE   = 5;

    localparam logic [TIME_W-1:0] SIMUL_GAP_MS = 32'd100;

    localparam logic [SRC_W-1:0] SRC_PAD_A   = 2'd0;
    localparam logic [SRC_W-1:0] SRC_PAD_B   = 2'd1;
    localparam logic [SRC_W-1:0] SRC_GESTURE = 2'd2;

    localparam logic [CODE_W-1:0] EV_SINGLE       = 3'd0;
    localparam logic [CODE_W-1:0] EV_DOUBLE       = 3'd1;
    localparam logic [CODE_W-1:0] EV_LONG         = 3'd2;
    localparam logic [CODE_W-1:0] EV_HOLD_START   = 3'd3;
    localparam logic [CODE_W-1:0] EV_HOLD_RELEASE = 3'd4;

    localparam logic [CODE_W-1:0] GS_SWIPE_AB      = 3'd0;
    localparam logic [CODE_W-1:0] GS_SWIPE_BA      = 3'd1;
    localparam logic [CODE_W-1:0] GS_SIMUL_PRESS   = 3'd2;
    localparam logic [CODE_W-1:0] GS_SIMUL_RELEASE = 3'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TAP_LIMIT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PRESS = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DOUBLE_TAP = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SWIPE      = 3'd4;

    typedef struct packed {
        logic [TIME_W-1:0] time_ms;
        logic              touch_a;
        logic              touch_b;
    } sample_t;

    typedef struct packed {
        logic [SRC_W-1:0]  source;
        logic [CODE_W-1:0] event_code;
        logic [TIME_W-1:0] stamp_ms;
        logic [TIME_W-1:0] duration_ms;
        logic              last;
    } result_t;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] tap_limit_ms;
        logic [CFG_W-1:0] long_press_ms;
        logic [CFG_W-1:0] double_tap_window_ms;
        logic [CFG_W-1:0] swipe_limit_ms;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] code;
        logic [TIME_W-1:0] duration;
    } pad_ev_t;

    typedef struct packed {
        logic [SRC_W-1:0]  source;
        logic [CODE_W-1:0] code;
        logic [TIME_W-1:0] duration;
    } slot_t;

    typedef struct packed {
        logic [TIME_W-1:0]           stamp_ms;
        logic [NUM_SLOTS-1:0]        mask;
        slot_t [NUM_SLOTS-1:0]       slots;
    } bundle_t;

endpackage

`default_nettype wire

FILE: rtl/dttgd_pad.sv
// ----------------------------------------------------------------------------
// Pad tap machine
// Debounces one pad and tracks taps, double taps, long press and hold.
// ----------------------------------------------------------------------------
`default_nettype none

module dttgd_pad
    import dttgd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   take,
    input  logic [TIME_W-1:0]      now,
    input  logic                   raw,
    input  cfg_t                   cfg,
    output logic                   level,
    output pad_ev_t [PAD_SLOTS-1:0] ev
);

    typedef enum logic [2:0] {
        MODE_IDLE     = 3'd0,
        MODE_PRESSED  = 3'd1,
        MODE_RELEASED = 3'd2,
        MODE_WAIT     = 3'd3,
        MODE_HOLDING  = 3'd4
    } mode_t;

    mode_t             mode_reg, mode_next;
    logic              raw_prev_reg;
    logic              stable_reg, stable_next;
    logic [TIME_W-1:0] deb_start_reg, deb_start_next;
    logic [TIME_W-1:0] press_start_reg, press_start_next;
    logic [TIME_W-1:0] release_reg, release_next;
    logic [1:0]        tap_reg, tap_next, tap_inc;
    logic              lpd_reg, lpd_next;
    logic              hsd_reg, hsd_next;

    logic [TIME_W-1:0] deb_elapsed;
    logic [TIME_W-1:0] held;
    logic [TIME_W-1:0] since_release;
    logic              changed;
    logic              down;

    always_comb
    begin
        deb_start_next = (raw != raw_prev_reg) ? now : deb_start_reg;
        deb_elapsed    = (raw != raw_prev_reg) ? '0 : now - deb_start_reg;
        changed        = (deb_elapsed >= {16'b0, cfg.debounce_ms}) && (raw != stable_reg);
        stable_next    = changed ? raw : stable_reg;
        down           = stable_next;
        held           = now - press_start_reg;
        since_release  = now - release_reg;
        tap_inc        = (tap_reg == 2'd3) ? tap_reg : tap_reg + 2'd1;

        mode_next        = mode_reg;
        press_start_next = press_start_reg;
        release_next     = release_reg;
        tap_next         = tap_reg;
        lpd_next         = lpd_reg;
        hsd_next         = hsd_reg;
        ev               = '0;

        case (mode_reg)
            MODE_PRESSED:
            begin
                if (changed && !down)
                begin
                    release_next = now;
                    if (held < {16'b0, cfg.tap_limit_ms})
                    begin
                        tap_next  = tap_inc;
                        mode_next = MODE_WAIT;
                    end
                    else
                    begin
                        tap_next  = '0;
                        mode_next = MODE_IDLE;
                    end
                end
                else if (!changed && down)
                begin
                    if (held >= {16'b0, cfg.long_press_ms} && !lpd_reg)
                    begin
                        lpd_next  = 1'b1;
                        ev[0]     = '{valid: 1'b1, code: EV_LONG, duration: held};
                        mode_next = MODE_HOLDING;
                    end
                end
            end
            MODE_WAIT:
            begin
                if (changed && down)
                begin
                    press_start_next = now;
                    if (tap_inc >= 2'd2)
                    begin
                        ev[0]     = '{valid: 1'b1, code: EV_DOUBLE, duration: '0};
                        tap_next  = '0;
                        mode_next = MODE_RELEASED;
                    end
                    else
                    begin
                        tap_next  = tap_inc;
                        mode_next = MODE_PRESSED;
                    end
                end
                else if (!changed && !down)
                begin
                    if (since_release >= {16'b0, cfg.double_tap_window_ms})
                    begin
                        if (tap_reg == 2'd1)
                        begin
                            ev[0] = '{valid: 1'b1, code: EV_SINGLE, duration: '0};
                        end
                        tap_next  = '0;
                        mode_next = MODE_IDLE;
                    end
                end
            end
            MODE_HOLDING:
            begin
                if (!hsd_reg)
                begin
                    ev[0]    = '{valid: 1'b1, code: EV_HOLD_START, duration: '0};
                    hsd_next = 1'b1;
                end
                if (changed && !down)
                begin
                    ev[1]     = '{valid: 1'b1, code: EV_HOLD_RELEASE, duration: held};
                    tap_next  = '0;
                    mode_next = MODE_IDLE;
                end
            end
            MODE_RELEASED:
            begin
                if (changed && !down)
                begin
                    tap_next  = '0;
                    mode_next = MODE_IDLE;
                end
            end
            default:
            begin
                mode_next = MODE_IDLE;
                if (changed && down)
                begin
                    mode_next        = MODE_PRESSED;
                    press_start_next = now;
                    lpd_next         = 1'b0;
                    hsd_next         = 1'b0;
                end
            end
        endcase
    end

    assign level = stable_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_IDLE;
            raw_prev_reg    <= 1'b0;
            stable_reg      <= 1'b0;
            deb_start_reg   <= '0;
            press_start_reg <= '0;
            release_reg     <= '0;
            tap_reg         <= '0;
            lpd_reg         <= 1'b0;
            hsd_reg         <= 1'b0;
        end
        else if (take)
        begin
            mode_reg        <= mode_next;
            raw_prev_reg    <= raw;
            stable_reg      <= stable_next;
            deb_start_reg   <= deb_start_next;
            press_start_reg <= press_start_next;
            release_reg     <= release_next;
            tap_reg         <= tap_next;
            lpd_reg         <= lpd_next;
            hsd_reg         <= hsd_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/dttgd_front.sv
// ----------------------------------------------------------------------------
// Detector front end
// Accepts samples, runs both pad machines and the two-pad gesture logic,
// and packs the events of one sample into a bundle for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dttgd_front
    import dttgd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    sample_valid,
    output logic    sample_ready,
    input  sample_t sample_item,
    input  cfg_t    cfg,
    input  logic    full,
    output logic    push,
    output bundle_t bundle
);

    logic                   take;
    logic                   level_a;
    logic                   level_b;
    pad_ev_t [PAD_SLOTS-1:0] ev_a;
    pad_ev_t [PAD_SLOTS-1:0] ev_b;

    logic [1:0]              gprev_reg;
    logic [TIME_W-1:0]       gpress_reg [2];
    logic [TIME_W-1:0]       gpress_next [2];

    logic              a_on, b_on, a_off, b_off;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] gap_to_a, gap_to_b;
    logic              simul_press, simul_release, swipe_ab, swipe_ba;

    assign sample_ready = !full;
    assign take         = sample_valid && !full;
    assign now          = sample_item.time_ms;

    dttgd_pad u_pad_a (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .now   (now),
        .raw   (sample_item.touch_a),
        .cfg   (cfg),
        .level (level_a),
        .ev    (ev_a)
    );

    dttgd_pad u_pad_b (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .now   (now),
        .raw   (sample_item.touch_b),
        .cfg   (cfg),
        .level (level_b),
        .ev    (ev_b)
    );

    always_comb
    begin
        a_on  = level_a && !gprev_reg[0];
        b_on  = level_b && !gprev_reg[1];
        a_off = !level_a && gprev_reg[0];
        b_off = !level_b && gprev_reg[1];

        gpress_next[0] = a_on ? now : gpress_reg[0];
        gpress_next[1] = b_on ? now : gpress_reg[1];
        gap_to_a       = now - gpress_next[0];
        gap_to_b       = now - gpress_next[1];

        if (a_on && level_b)
        begin
            simul_press = gap_to_b < SIMUL_GAP_MS;
        end
        else if (b_on && level_a)
        begin
            simul_press = gap_to_a < SIMUL_GAP_MS;
        end
        else
        begin
            simul_press = 1'b0;
        end
        simul_release = a_off && b_off;
        swipe_ab = b_on && gprev_reg[0] && (gap_to_a != '0)
                   && (gap_to_a < {16'b0, cfg.swipe_limit_ms});
        swipe_ba = a_on && gprev_reg[1] && (gap_to_b != '0)
                   && (gap_to_b < {16'b0, cfg.swipe_limit_ms});

        bundle          = '0;
        bundle.stamp_ms = now;
        for (int i = 0; i < PAD_SLOTS; i++)
        begin
            bundle.mask[SLOT_PAD_A + i]  = ev_a[i].valid;
            bundle.slots[SLOT_PAD_A + i] = '{source: SRC_PAD_A, code: ev_a[i].code,
                                             duration: ev_a[i].duration};
            bundle.mask[SLOT_PAD_B + i]  = ev_b[i].valid;
            bundle.slots[SLOT_PAD_B + i] = '{source: SRC_PAD_B, code: ev_b[i].code,
                                             duration: ev_b[i].duration};
        end
        bundle.mask[SLOT_SIMUL]  = simul_press || simul_release;
        bundle.slots[SLOT_SIMUL] = '{source: SRC_GESTURE,
                                     code: simul_press ? GS_SIMUL_PRESS : GS_SIMUL_RELEASE,
                                     duration: '0};
        bundle.mask[SLOT_SWIPE]  = swipe_ab || swipe_ba;
        bundle.slots[SLOT_SWIPE] = '{source: SRC_GESTURE,
                                     code: swipe_ab ? GS_SWIPE_AB : GS_SWIPE_BA,
                                     duration: swipe_ab ? gap_to_a : gap_to_b};
    end

    assign push = take && (bundle.mask != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gprev_reg     <= '0;
            gpress_reg[0] <= '0;
            gpress_reg[1] <= '0;
        end
        else if (take)
        begin
            gprev_reg     <= {level_b, level_a};
            gpress_reg[0] <= gpress_next[0];
            gpress_reg[1] <= gpress_next[1];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/dttgd_queue.sv
// ----------------------------------------------------------------------------
// Event bundle queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dttgd_queue
    import dttgd_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  bundle_t din,
    output logic    full,
    input  logic    pop,
    output logic    head_valid,
    output bundle_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    bundle_t          mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `ASSERT_NEVER(a_push_full, push && full, "Item pushed into a full queue.")
    `ASSERT_NEVER(a_pop_empty, pop && !head_valid, "Item popped from an empty queue.")
    `ASSERT_PROP(a_count_step, push && !pop |=> count_reg == $past(count_reg) + 1'b1, "Queue count did not follow a push.")

endmodule

`default_nettype wire

FILE: rtl/dttgd_back.sv
// ----------------------------------------------------------------------------
// Detector back end
// Sends the events of the bundle at the queue head one at a time through
// the output register, in slot order, and marks the final one.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dttgd_back
    import dttgd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    head_valid,
    input  bundle_t head,
    output logic    pop,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result_item
);

    logic [NUM_SLOTS-1:0] sent_reg;
    logic [NUM_SLOTS-1:0] remaining;
    logic [NUM_SLOTS-1:0] pick;
    logic                 is_last;
    logic                 load;
    slot_t                chosen;
    logic                 result_valid_reg;
    result_t              result_reg;

    always_comb
    begin
        remaining = head.mask & ~sent_reg;
        pick      = remaining & (~remaining + 1'b1);
        is_last   = (remaining & ~pick) == '0;
        chosen    = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (pick[i])
            begin
                chosen = head.slots[i];
            end
        end
    end

    assign load = head_valid && (!result_valid_reg || result_ready);
    assign pop  = load && is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sent_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                result_valid_reg <= 1'b1;
                sent_reg         <= is_last ? '0 : (sent_reg | pick);
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= '{source: chosen.source, event_code: chosen.code,
                            stamp_ms: head.stamp_ms, duration_ms: chosen.duration,
                            last: is_last};
        end
    end

    assign result_valid = result_valid_reg;
    assign result_item  = result_reg;

    `ASSERT_NEVER(a_head_empty, head_valid && (remaining == '0), "Queued bundle is empty.")
    `ASSERT_PROP(a_pick_onehot, head_valid |-> $onehot0(pick), "More than one slot picked.")
    `ASSERT_PROP(a_pop_clears, pop |=> sent_reg == '0, "Sent mask not cleared.")

endmodule

`default_nettype wire

FILE: rtl/dual_touch_tap_gesture_detector.sv
// ----------------------------------------------------------------------------
// Dual touch tap gesture detector
// Debounced tap, double tap, long press and hold events for two touch pads,
// plus simultaneous press, simultaneous release and swipe gestures.
// ----------------------------------------------------------------------------
// A sample is accepted in every cycle while the internal queue has room; its
// state update is registered on acceptance. Each event then leaves through
// the output register at one result per cycle while result_ready is high, so
// a sample gives one result per event, and one with no event is not queued.
// The queue of QUEUE_DEPTH bundles absorbs bursts; sample_ready drops only
// when it is full. Registers are written through the cfg port, which is always
// ready; writes to an index past the last register are ignored.
`default_nettype none

module dual_touch_tap_gesture_detector
    import dttgd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   sample_valid,
    output logic                   sample_ready,
    input  sample_t                sample_item,
    output logic                   result_valid,
    input  logic                   result_ready,
    output result_t                result_item,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    cfg_t    cfg_reg;
    logic    full;
    logic    push;
    logic    pop;
    logic    head_valid;
    bundle_t bundle;
    bundle_t head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms          <= 16'd50;
            cfg_reg.tap_limit_ms         <= 16'd300;
            cfg_reg.long_press_ms        <= 16'd1000;
            cfg_reg.double_tap_window_ms <= 16'd300;
            cfg_reg.swipe_limit_ms       <= 16'd500;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_DEBOUNCE:   cfg_reg.debounce_ms          <= cfg_data;
                CFG_TAP_LIMIT:  cfg_reg.tap_limit_ms         <= cfg_data;
                CFG_LONG_PRESS: cfg_reg.long_press_ms        <= cfg_data;
                CFG_DOUBLE_TAP: cfg_reg.double_tap_window_ms <= cfg_data;
                CFG_SWIPE:      cfg_reg.swipe_limit_ms       <= cfg_data;
                default:        ;
            endcase
        end
    end

    dttgd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_item  (sample_item),
        .cfg          (cfg_reg),
        .full         (full),
        .push         (push),
        .bundle       (bundle)
    );

    dttgd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .din        (bundle),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    dttgd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

endmodule

`default_nettype wire
